[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/b64d_pkg.sv]
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int POS_BITS   = 16;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD,
        PH_TRAIL,
        PH_STOP
    } phase_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_LEFTOVER    = 3'd1;
    localparam logic [2:0] ST_PAD_MISSING = 3'd2;
    localparam logic [2:0] ST_BAD_PAD     = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;
    localparam logic [2:0] ST_UNCONSUMED  = 3'd5;

    localparam logic [2:0] REG_URLSAFE    = 3'd0;
    localparam logic [2:0] REG_PAD_OMIT   = 3'd1;
    localparam logic [2:0] REG_IGN_LOW    = 3'd2;
    localparam logic [2:0] REG_IGN_MID    = 3'd3;
    localparam logic [2:0] REG_IGN_HIGH   = 3'd4;
    localparam logic [2:0] REG_IGN_TOP    = 3'd5;
    localparam logic [2:0] REG_OUT_LIMIT  = 3'd6;
    localparam logic [2:0] REG_EARLY_STOP = 3'd7;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } dec6_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] byte_count;
        logic [15:0] stop_position;
    } result_t;

    function automatic dec6_t b64d_decode(input logic [7:0] c, input logic urlsafe);
        dec6_t d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            d.val = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]}) begin
            d.val = 6'(c - 8'h47);
        end
        else if (c inside {[8'h30:8'h39]}) begin
            d.val = 6'(c + 8'h04);
        end
        else if (c == (urlsafe ? CHAR_MINUS : CHAR_PLUS)) begin
            d.val = 6'd62;
        end
        else if (c == (urlsafe ? CHAR_UNDER : CHAR_SLASH)) begin
            d.val = 6'd63;
        end
        else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    // Leftover bits are bad when more than four remain or any of them is set.
    function automatic logic b64d_leftover_bad(input logic [11:0] acc, input logic [3:0] cnt);
        logic [11:0] mask;
        mask = ~(12'(12'hFFF << cnt));
        return (cnt > 4'd4) || ((acc & mask) != 12'd0);
    endfunction

endpackage

[rtl/base64_stream_decoder.sv]
// Streaming Base64 decoder.
// Text enters on the slave stream one character per word: tdata carries the
// character code and tlast marks the final character of a text. Results leave
// on the master stream. A byte word has tuser high and the decoded byte in
// tdata. The closing word of a text has tlast high and carries the status,
// the byte count (zero on any error, in which case the bytes already sent
// must be discarded) and the position of the first character not consumed.
// A character is taken every cycle while tready is high; it goes from the
// input register into the result queue, whose head drives the master side.
// A four-word result queue decouples the two sides, so the slave side keeps
// accepting while the receiver stalls, until the queue cannot take two more
// words; then tready drops and nothing is lost. The configuration registers
// are written through cfg_we, cfg_index and cfg_data while no text is in
// flight. Reset clears the run state and the queue and loads the register
// defaults: standard alphabet, padding required, no ignored characters,
// an output limit of 65535 bytes and early stop not allowed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_char
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_byte, status, byte_count, stop_position
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast,   // done_res
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic          urlsafe_reg;
    logic          pad_omit_reg;
    logic [255:0]  ign_map_reg;
    logic [15:0]   limit_reg;
    logic          early_reg;

    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          in_last_reg;

    phase_t        phase_reg, phase_next;
    logic [11:0]   acc_reg, acc_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [1:0]    padl_reg, padl_next;
    logic [15:0]   prod_reg, prod_next;
    pos_t          pos_reg, pos_next;
    logic [2:0]    err_reg, err_next;

    result_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]       count_reg, count_next;

    logic          fire;
    logic          pop;
    phase_t        cur_ph;
    dec6_t         dec;
    logic          ign;
    logic [11:0]   acc6;
    logic [3:0]    cnt6;
    logic [3:0]    cnt8;
    pos_t          pos_inc;
    logic          emit;
    logic [7:0]    emit_byte;
    logic [2:0]    err_fin;
    logic [2:0]    status_fin;
    result_t       byte_res, fin_res, res0;
    logic [1:0]    npush;
    result_t       head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            urlsafe_reg  <= 1'b0;
            pad_omit_reg <= 1'b0;
            ign_map_reg  <= '0;
            limit_reg    <= 16'hFFFF;
            early_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_URLSAFE:    urlsafe_reg          <= cfg_data[0];
                REG_PAD_OMIT:   pad_omit_reg         <= cfg_data[0];
                REG_IGN_LOW:    ign_map_reg[63:0]    <= cfg_data;
                REG_IGN_MID:    ign_map_reg[127:64]  <= cfg_data;
                REG_IGN_HIGH:   ign_map_reg[191:128] <= cfg_data;
                REG_IGN_TOP:    ign_map_reg[255:192] <= cfg_data;
                REG_OUT_LIMIT:  limit_reg            <= cfg_data[15:0];
                REG_EARLY_STOP: early_reg            <= cfg_data[0];
                default:        early_reg            <= early_reg;
            endcase
        end
    end

    // Input register.
    assign fire          = in_valid_reg && (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Decode of one character against the run state.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        padl_next  = padl_reg;
        prod_next  = prod_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        emit       = 1'b0;
        emit_byte  = '0;
        cur_ph     = phase_reg;
        dec        = b64d_decode(in_char_reg, urlsafe_reg);
        ign        = ign_map_reg[in_char_reg];
        acc6       = {acc_reg[5:0], dec.val};
        cnt6       = cnt_reg + 4'd6;
        cnt8       = cnt6 - 4'd8;
        pos_inc    = pos_reg + pos_t'(1);

        if (cur_ph == PH_DATA)
        begin
            if (dec.ok)
            begin
                acc_next = acc6;
                if (cnt6 >= 4'd8)
                begin
                    cnt_next = cnt8;
                    if (prod_reg >= limit_reg)
                    begin
                        err_next   = ST_FULL;
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_byte = 8'(acc6 >> cnt8);
                        prod_next = prod_reg + 16'd1;
                        pos_next  = pos_inc;
                    end
                end
                else
                begin
                    cnt_next = cnt6;
                    pos_next = pos_inc;
                end
            end
            else if (ign)
            begin
                pos_next = pos_inc;
            end
            else if (b64d_leftover_bad(acc_reg, cnt_reg))
            begin
                err_next   = ST_LEFTOVER;
                phase_next = PH_STOP;
            end
            else if (!pad_omit_reg && (cnt_reg[3:1] != 3'd0))
            begin
                padl_next = cnt_reg[2:1];
                cur_ph    = PH_PAD;
            end
            else
            begin
                cur_ph = PH_TRAIL;
            end
        end

        if (cur_ph == PH_PAD)
        begin
            phase_next = PH_PAD;
            if (in_char_reg == CHAR_PAD)
            begin
                padl_next = padl_next - 2'd1;
                pos_next  = pos_inc;
                if (padl_next == 2'd0)
                begin
                    phase_next = PH_TRAIL;
                end
            end
            else if (ign)
            begin
                pos_next = pos_inc;
            end
            else
            begin
                err_next   = ST_BAD_PAD;
                phase_next = PH_STOP;
            end
        end
        else if (cur_ph == PH_TRAIL)
        begin
            phase_next = PH_TRAIL;
            if (ign)
            begin
                pos_next = pos_inc;
            end
            else
            begin
                phase_next = PH_STOP;
            end
        end

        // Closing checks on the final character.
        err_fin = err_next;
        if (phase_next == PH_DATA)
        begin
            if (b64d_leftover_bad(acc_next, cnt_next))
            begin
                err_fin = ST_LEFTOVER;
            end
            else if (!pad_omit_reg && (cnt_next[3:1] != 3'd0))
            begin
                err_fin = ST_PAD_MISSING;
            end
        end
        else if (phase_next == PH_PAD)
        begin
            err_fin = ST_PAD_MISSING;
        end
        status_fin = err_fin;
        if ((err_fin == ST_OK) && (phase_next == PH_STOP) && !early_reg)
        begin
            status_fin = ST_UNCONSUMED;
        end

        byte_res               = '0;
        byte_res.out_byte      = emit_byte;
        byte_res.byte_valid    = 1'b1;
        fin_res                = '0;
        fin_res.done_res       = 1'b1;
        fin_res.status         = status_fin;
        fin_res.byte_count     = (status_fin == ST_OK) ? prod_next : 16'd0;
        fin_res.stop_position  = 16'(pos_next);
        res0                   = emit ? byte_res : fin_res;
        npush                  = {1'b0, emit} + {1'b0, in_last_reg};

        if (in_last_reg)
        begin
            phase_next = PH_DATA;
            acc_next   = '0;
            cnt_next   = '0;
            padl_next  = '0;
            prod_next  = '0;
            pos_next   = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DATA;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            padl_reg  <= '0;
            prod_reg  <= '0;
            pos_reg   <= '0;
            err_reg   <= ST_OK;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            padl_reg  <= padl_next;
            prod_reg  <= prod_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

    // Result queue.
    assign pop         = m_axis_tvalid && m_axis_tready;
    assign wr_ptr_next = fire ? wr_ptr_reg + FIFO_AW'(npush) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
    assign count_next  = count_reg + (fire ? (FIFO_AW+1)'(npush) : '0)
                         - (FIFO_AW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (npush != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (fire && (npush == 2'd2))
        begin
            fifo_reg[wr_ptr_reg + FIFO_AW'(1)] <= fin_res;
        end
    end

    assign head          = fifo_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {5'b0, head.stop_position, head.byte_count, head.status,
                            head.out_byte};
    assign m_axis_tuser  = head.byte_valid;
    assign m_axis_tlast  = head.done_res;

    `ASSERT_IMPL(a_queue_bound, clk, rst_n, 1'b1, count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
    `ASSERT_IMPL(a_error_no_count, clk, rst_n,
                 m_axis_tvalid && m_axis_tlast && (head.status != ST_OK),
                 head.byte_count == 16'd0)
    `ASSERT_NEXT(a_run_cleared, clk, rst_n, fire && in_last_reg,
                 (phase_reg == PH_DATA) && (pos_reg == '0) && (prod_reg == 16'd0))
    `ASSERT_IMPL(a_no_fire_when_full, clk, rst_n,
                 count_reg > (FIFO_AW+1)'(FIFO_DEPTH - 2), !fire)

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] ch;
        logic       is_end;
    } text_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [63:0] cfg_data = 64'd0;

    base64_stream_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // Decoder settings as the predictor sees them.
    logic        url_mode = 1'b0;
    logic        no_pad = 1'b0;
    logic [63:0] skip_map [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
    logic [15:0] byte_limit = 16'hFFFF;
    logic        early_ok = 1'b0;

    // Decoder run state as the predictor sees it.
    phase_t      dec_phase = PH_DATA;
    logic [11:0] acc = 12'd0;
    logic [3:0]  nbits = 4'd0;
    logic [1:0]  pads_owed = 2'd0;
    logic [15:0] out_total = 16'd0;
    pos_t        char_pos = '0;
    logic [2:0]  err = ST_OK;

    result_t     out_words_due [$];
    text_word_t  char_queue [$];
    logic [7:0]  text_buf [$];
    logic [7:0]  skip_codes [$];

    int          chars_outstanding = 0;
    int          chars_made = 0;
    int          texts_made = 0;
    int          settings_made = 0;
    int          errors = 0;
    int          words_seen = 0;
    int          bytes_checked = 0;
    int          closes_checked = 0;
    logic [5:0]  status_seen = 6'd0;
    int          cycle_count = 0;
    bit          busy = 1'b1;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          hold_left = 0;

    function automatic logic sextet_of(input logic [7:0] c, output logic [5:0] v);
        v = 6'd0;
        if (c >= "A" && c <= "Z")
            v = 6'(c - 8'd65);
        else if (c >= "a" && c <= "z")
            v = 6'(c - 8'd71);
        else if (c >= "0" && c <= "9")
            v = 6'(c + 8'd4);
        else if (c == (url_mode ? CHAR_MINUS : CHAR_PLUS))
            v = 6'd62;
        else if (c == (url_mode ? CHAR_UNDER : CHAR_SLASH))
            v = 6'd63;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'd65 + 8'(v);
        if (v < 6'd52)
            return 8'd71 + 8'(v);
        if (v < 6'd62)
            return 8'(v) - 8'd4;
        if (v == 6'd62)
            return url_mode ? CHAR_MINUS : CHAR_PLUS;
        return url_mode ? CHAR_UNDER : CHAR_SLASH;
    endfunction

    function automatic logic skipped(input logic [7:0] c);
        return skip_map[c[7:6]][c[5:0]];
    endfunction

    function automatic logic tail_bad();
        logic [11:0] low_bits;
        low_bits = acc << (4'd12 - nbits);
        return (nbits > 4'd4) || (low_bits != 12'd0);
    endfunction

    task automatic clear_run();
        dec_phase = PH_DATA;
        acc = 12'd0;
        nbits = 4'd0;
        pads_owed = 2'd0;
        out_total = 16'd0;
        char_pos = '0;
        err = ST_OK;
    endtask

    task automatic push_result(input logic [7:0] b, input logic bv, input logic dn,
                               input logic [2:0] st, input logic [15:0] cnt,
                               input logic [15:0] pos);
        result_t r;
        r.out_byte = b;
        r.byte_valid = bv;
        r.done_res = dn;
        r.status = st;
        r.byte_count = cnt;
        r.stop_position = pos;
        out_words_due.push_back(r);
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [5:0]  v;
        logic        hit;
        logic [11:0] shifted;
        hit = sextet_of(c, v);
        if (dec_phase == PH_DATA) begin
            if (hit) begin
                acc = {acc[5:0], v};
                nbits = nbits + 4'd6;
                if (nbits >= 4'd8) begin
                    nbits = nbits - 4'd8;
                    if (out_total >= byte_limit) begin
                        err = ST_FULL;
                        dec_phase = PH_STOP;
                        return;
                    end
                    shifted = acc >> nbits;
                    push_result(shifted[7:0], 1'b1, 1'b0, ST_OK, 16'd0, 16'd0);
                    out_total = out_total + 16'd1;
                end
                char_pos = char_pos + 1'b1;
                return;
            end
            if (skipped(c)) begin
                char_pos = char_pos + 1'b1;
                return;
            end
            if (tail_bad()) begin
                err = ST_LEFTOVER;
                dec_phase = PH_STOP;
                return;
            end
            if (!no_pad && (nbits >> 1) != 4'd0) begin
                pads_owed = 2'(nbits >> 1);
                dec_phase = PH_PAD;
            end
            else begin
                dec_phase = PH_TRAIL;
            end
        end
        if (dec_phase == PH_PAD) begin
            if (c == CHAR_PAD) begin
                pads_owed = pads_owed - 2'd1;
                char_pos = char_pos + 1'b1;
                if (pads_owed == 2'd0)
                    dec_phase = PH_TRAIL;
                return;
            end
            if (skipped(c)) begin
                char_pos = char_pos + 1'b1;
                return;
            end
            err = ST_BAD_PAD;
            dec_phase = PH_STOP;
            return;
        end
        if (dec_phase == PH_TRAIL) begin
            if (skipped(c))
                char_pos = char_pos + 1'b1;
            else
                dec_phase = PH_STOP;
        end
    endtask

    task automatic decode_step(input logic [7:0] c, input logic is_end);
        logic [2:0] st;
        absorb_char(c);
        if (is_end) begin
            if (dec_phase == PH_DATA) begin
                if (tail_bad())
                    err = ST_LEFTOVER;
                else if (!no_pad && (nbits >> 1) != 4'd0)
                    err = ST_PAD_MISSING;
            end
            else if (dec_phase == PH_PAD) begin
                err = ST_PAD_MISSING;
            end
            st = err;
            if (st == ST_OK && dec_phase == PH_STOP && !early_ok)
                st = ST_UNCONSUMED;
            push_result(8'd0, 1'b0, 1'b1, st, (st == ST_OK) ? out_total : 16'd0,
                        16'(char_pos));
            clear_run();
        end
    endtask

    task automatic same(input string what, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    task automatic check_word();
        result_t want;
        if (out_words_due.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected word, expected none, actual %h user %b last %b",
                     $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
        else begin
            want = out_words_due.pop_front();
            same("out_byte", 16'(want.out_byte), 16'(m_axis_tdata[7:0]));
            same("byte_valid", 16'(want.byte_valid), 16'(m_axis_tuser));
            same("done_res", 16'(want.done_res), 16'(m_axis_tlast));
            same("status", 16'(want.status), 16'(m_axis_tdata[10:8]));
            same("byte_count", want.byte_count, m_axis_tdata[26:11]);
            same("stop_position", want.stop_position, m_axis_tdata[42:27]);
            if (want.done_res) begin
                closes_checked++;
                status_seen[want.status] = 1'b1;
            end
            else begin
                bytes_checked++;
            end
        end
    endtask

    always @(posedge clk) begin : drive_blk
        text_word_t w;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_step(s_axis_tdata, s_axis_tlast);
                chars_outstanding--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (char_queue.size() > 0) begin
                    w = char_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= w.ch;
                    s_axis_tlast <= w.is_end;
                    if (busy && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 18);
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_word();
                words_seen++;
                // A long hold-off lets the result queue fill and stall the input.
                if (words_seen == 80 || words_seen == 300)
                    hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
                if (busy && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d words still expected",
                     $time, cycle_count, out_words_due.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_URLSAFE:    url_mode = val[0];
            REG_PAD_OMIT:   no_pad = val[0];
            REG_IGN_LOW:    skip_map[0] = val;
            REG_IGN_MID:    skip_map[1] = val;
            REG_IGN_HIGH:   skip_map[2] = val;
            REG_IGN_TOP:    skip_map[3] = val;
            REG_OUT_LIMIT:  byte_limit = val[15:0];
            REG_EARLY_STOP: early_ok = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] junk_above(input int lsbs, input logic [63:0] val);
        logic [63:0] r;
        r = {$urandom, $urandom};
        r = (r << lsbs) | (val & ((64'd1 << lsbs) - 64'd1));
        return r;
    endfunction

    task automatic apply_settings(input logic url, input logic np, input logic [63:0] m0,
                                  input logic [63:0] m1, input logic [63:0] m2,
                                  input logic [63:0] m3, input logic [15:0] lim,
                                  input logic es);
        logic [5:0] v;
        write_reg(REG_URLSAFE, junk_above(1, 64'(url)));
        write_reg(REG_PAD_OMIT, junk_above(1, 64'(np)));
        write_reg(REG_IGN_LOW, m0);
        write_reg(REG_IGN_MID, m1);
        write_reg(REG_IGN_HIGH, m2);
        write_reg(REG_IGN_TOP, m3);
        write_reg(REG_OUT_LIMIT, junk_above(16, 64'(lim)));
        write_reg(REG_EARLY_STOP, junk_above(1, 64'(es)));
        @(posedge clk);
        cfg_we <= 1'b0;
        skip_codes.delete();
        for (int i = 0; i < 256; i++)
            if (skipped(8'(i)) && !sextet_of(8'(i), v) && 8'(i) != CHAR_PAD)
                skip_codes.push_back(8'(i));
        settings_made++;
    endtask

    function automatic logic [63:0] pick_map(input int lane);
        logic [63:0] spaces;
        spaces = (64'd1 << 9) | (64'd1 << 10) | (64'd1 << 13) | (64'd1 << 32);
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return {64{1'b1}};
            2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3: return (lane == 0) ? spaces | (64'($urandom_range(0, 1)) << 61) : 64'd0;
            default: return (lane == 0) ? spaces : {$urandom, $urandom} & {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1, 2, 3: return 16'hFFFF;
            4, 5: return 16'($urandom);
            default: return 16'($urandom_range(1, 30));
        endcase
    endfunction

    task automatic random_settings();
        apply_settings(1'($urandom), 1'($urandom), pick_map(0), pick_map(1), pick_map(2),
                       pick_map(3), pick_limit(), 1'($urandom));
    endtask

    task automatic put_char(input logic [7:0] c);
        text_buf.push_back(c);
        if (skip_codes.size() > 0 && $urandom_range(0, 5) == 0)
            text_buf.push_back(skip_codes[$urandom_range(0, skip_codes.size() - 1)]);
    endtask

    task automatic encode_bytes(input int n_bytes, input bit with_pad);
        logic [23:0] grp;
        int          k;
        int          i;
        i = 0;
        while (i < n_bytes) begin
            k = (n_bytes - i >= 3) ? 3 : n_bytes - i;
            grp = 24'($urandom);
            if (k < 3)
                grp[7:0] = 8'd0;
            if (k < 2)
                grp[15:8] = 8'd0;
            for (int j = 0; j <= k; j++)
                put_char(alphabet_char(grp[23 - 6 * j -: 6]));
            if (with_pad)
                for (int j = k; j < 3; j++)
                    put_char(CHAR_PAD);
            i += k;
        end
    endtask

    task automatic flush_text();
        text_word_t w;
        if (text_buf.size() == 0)
            text_buf.push_back(8'($urandom));
        foreach (text_buf[i]) begin
            w.ch = text_buf[i];
            w.is_end = (i == text_buf.size() - 1);
            char_queue.push_back(w);
            chars_outstanding++;
            chars_made++;
        end
        text_buf.delete();
        texts_made++;
    endtask

    task automatic string_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        flush_text();
    endtask

    task automatic random_text();
        int         kind;
        int         nb;
        int         pos;
        logic [5:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 45) : $urandom_range(0, 12);
            encode_bytes(nb, no_pad ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) != 0));
            repeat ($urandom_range(0, 2))
                if (skip_codes.size() > 0)
                    text_buf.push_back(skip_codes[$urandom_range(0, skip_codes.size() - 1)]);
            if (kind >= 65 && text_buf.size() > 0) begin
                pos = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 3))
                    0: text_buf[pos] = 8'($urandom);
                    1: if (text_buf.size() > 1) void'(text_buf.pop_back());
                    2: text_buf.push_back(8'($urandom));
                    default: text_buf.insert(pos, CHAR_PAD);
                endcase
            end
        end
        else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(CHAR_PAD);
                    1: text_buf.push_back(alphabet_char(6'($urandom)));
                    2: text_buf.push_back(skip_codes.size() > 0 ?
                           skip_codes[$urandom_range(0, skip_codes.size() - 1)] : 8'($urandom));
                    default: text_buf.push_back(8'($urandom));
                endcase
            end
        end
        flush_text();
    endtask

    task automatic fill_texts(input int n_chars);
        int stop_at;
        stop_at = chars_made + n_chars;
        while (chars_made < stop_at)
            random_text();
    endtask

    task automatic settle();
        while (chars_outstanding != 0 || out_words_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        string_text("TQ==");
        string_text("AP/+");
        string_text("TR==");
        string_text("TQ=");
        string_text("TQ=x");
        string_text("T");
        string_text("TQ==!A");
        settle();

        apply_settings(1'b0, 1'b0,
                       (64'd1 << 9) | (64'd1 << 10) | (64'd1 << 32) | (64'd1 << 61),
                       64'd0, 64'd0, 64'd0, 16'hFFFF, 1'b0);
        fill_texts(120);
        settle();

        apply_settings(1'b1, 1'b1, pick_map(2), pick_map(2), pick_map(2), pick_map(2),
                       16'd7, 1'b1);
        fill_texts(100);
        settle();

        apply_settings(1'b0, 1'b1, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                       16'd0, 1'b0);
        fill_texts(60);
        settle();

        while (chars_made < 820) begin
            busy = ($urandom_range(0, 9) < 7);
            random_settings();
            fill_texts(90);
            settle();
        end

        busy = 1'b0;
        random_settings();
        fill_texts(80);
        settle();

        $display("testbench: %0d texts, %0d characters, %0d register settings",
                 texts_made, chars_made, settings_made);
        $display("testbench: %0d byte words and %0d closing words checked, statuses seen %b",
                 bytes_checked, closes_checked, status_seen);
        if (errors == 0 && out_words_due.size() == 0) begin
            $display("testbench: done, clean");
        end
        else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
